// ===== hdl/bmw_pkg.sv =====
// bmw_pkg: shared types and constants for the binary morphology window
// fixed field widths, mode codes, register indexes and the cell match struct
// no dependencies
package bmw_pkg;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int POS_W      = 10;
    localparam int MODE_W     = 3;
    localparam int SIZE_W     = 11;
    localparam int RAD_W      = 2;
    localparam int SE_W       = 25;
    localparam int SE_IDX_W   = 5;
    localparam int OFS_W      = RAD_W + 1;
    localparam int BIT_W      = 2 * OFS_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SE_W;

    // pixel levels
    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_ERODE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DILATE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUBTRACT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UNION    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INTERSECT = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAD_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAD_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SE     = 3'd5;

    // per-column window result: some masked pixel set / some masked pixel clear
    typedef struct packed {
        logic hit;
        logic miss;
    } match_t;

endpackage

// ===== hdl/bmw_cell.sv =====
// bmw_cell: one column of the sliding window
// holds a column vector of stored row bits, passes it on, and matches it
// against its mask column; depends on bmw_pkg
module bmw_cell
    import bmw_pkg::*;
#(
    parameter int ROWS = 5
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  logic [ROWS-1:0] col_in,
    input  logic [ROWS-1:0] mask,
    output logic [ROWS-1:0] col_out,
    output match_t          cell_match
);

    logic [ROWS-1:0] col_reg;

    // column register, moves one place per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    // match of the held column under the mask
    always_comb
    begin
        cell_match.hit  = |(col_reg & mask);
        cell_match.miss = |(~col_reg & mask);
    end

endmodule

// ===== hdl/binary_morphology_window_top.sv =====
// binary_morphology_window_top: binary erosion, dilation and set operations
// on a raster pixel stream; uses bmw_pkg and a chain of bmw_cell columns
// holds the line store memory and the configuration registers
//
// Usage:
//   Input channel (in_valid/in_ready) takes one pixel per transaction in
//   raster order with its co-located second pixel and a frame_start flag.
//   Output channel (out_valid/out_ready) gives zero or one result per pixel:
//   erosion/dilation give a result only for interior window centres, the set
//   modes give one for every pixel.
//   Path: a result passes the read stage register, then the output register.
//   Throughput: one pixel per cycle while out_ready is high after the sweep;
//   the memory read of the newest pixel's column and the chain shift set the pace.
//   Reset: registers take their reset values, then a sweep clears the line
//   store one column per cycle, all MAX_WIDTH columns, with in_ready low.
//   Configuration writes are taken at any time, also during the sweep.
//   Stall: while out_ready is low the output holds; one more pixel may be
//   taken into the read stage, then in_ready drops until the result leaves.
//   The user changes configuration only with no transaction in flight (unchecked).
module binary_morphology_window_top
    import bmw_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_RADIUS = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      pixel,
    input  logic [PIX_W-1:0]      second_pixel,
    input  logic                  frame_start,
    // output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      out_value,
    output logic [POS_W-1:0]      out_col,
    output logic [POS_W-1:0]      out_row,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ROWS = 2 * MAX_RADIUS + 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CW1  = CW + 1;
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int RW1  = RW + 1;
    localparam int SW   = $clog2(ROWS);
    localparam int SW1  = SW + 1;
    localparam int WB   = (CW1 > SIZE_W) ? CW1 : SIZE_W;
    localparam int HB   = (RW1 > SIZE_W) ? RW1 : SIZE_W;

    // configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [SIZE_W-1:0] image_width_reg;
    logic [SIZE_W-1:0] image_height_reg;
    logic [RAD_W-1:0]  radius_x_reg;
    logic [RAD_W-1:0]  radius_y_reg;
    logic [SE_W-1:0]   se_reg;

    // position and clear sweep
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          clr_busy_reg;
    logic [CW-1:0] clr_addr_reg;

    // read stage
    logic            s1_valid_reg;
    logic [CW-1:0]   s1_col_reg;
    logic [RW-1:0]   s1_row_reg;
    logic [SW-1:0]   s1_slot_reg;
    logic            s1_bit_reg;
    logic            s1_px_nz_reg;
    logic            s1_px2_nz_reg;
    logic [ROWS-1:0] s1_rd_reg;

    // line store: one bit per stored row slot, one word per column
    logic [ROWS-1:0] mem [MAX_WIDTH];

    // output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_value_reg;
    logic [POS_W-1:0] out_col_reg;
    logic [POS_W-1:0] out_row_reg;

    // effective sizes and radii
    logic [WB-1:0]    w_wide;
    logic [HB-1:0]    h_wide;
    logic [CW1-1:0]   w_eff;
    logic [RW1-1:0]   h_eff;
    logic [RAD_W-1:0] rx;
    logic [RAD_W-1:0] ry;
    logic [OFS_W-1:0] two_rx;
    logic [OFS_W-1:0] two_ry;
    logic [OFS_W-1:0] span;

    // accept stage
    logic          accept;
    logic          adv;
    logic          s1_fire;
    logic [CW-1:0] col_start, col_cur;
    logic [RW-1:0] row_start, row_cur;
    logic [SW-1:0] slot_start, slot_cur;
    logic          row_wrap;
    logic [CW1-1:0] col_inc;
    logic [RW1-1:0] row_inc;
    logic          pix_bit;

    // window evaluation
    logic [ROWS-1:0]  fresh;
    logic [ROWS-1:0]  mask_tap [ROWS];
    logic [ROWS-1:0]  col_chain [ROWS];
    match_t           cell_res [ROWS-1];
    logic [SW-1:0]    back_s [ROWS];
    logic             row_ok [ROWS];
    logic [OFS_W-1:0] ofs_i [ROWS];
    logic             hit_any;
    logic             miss_any;
    logic             morph_mode;
    logic             set_mode;
    logic             has_result;
    logic             res_bit;
    logic [POS_W-1:0] res_col;
    logic [POS_W-1:0] res_row;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_ERODE;
            image_width_reg  <= 11'd1024;
            image_height_reg <= 11'd1024;
            radius_x_reg     <= 2'd1;
            radius_y_reg     <= 2'd1;
            se_reg           <= 25'd511;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg         <= cfg_data[MODE_W-1:0];
                REG_WIDTH:  image_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT: image_height_reg <= cfg_data[SIZE_W-1:0];
                REG_RAD_X:  radius_x_reg     <= cfg_data[RAD_W-1:0];
                REG_RAD_Y:  radius_y_reg     <= cfg_data[RAD_W-1:0];
                REG_SE:     se_reg           <= cfg_data[SE_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamp sizes and radii
    always_comb
    begin
        w_wide = WB'(image_width_reg);
        h_wide = HB'(image_height_reg);
        if (w_wide == '0)
            w_eff = CW1'(1);
        else if (w_wide > WB'(MAX_WIDTH))
            w_eff = CW1'(MAX_WIDTH);
        else
            w_eff = CW1'(w_wide);
        if (h_wide == '0)
            h_eff = RW1'(1);
        else if (h_wide > HB'(MAX_HEIGHT))
            h_eff = RW1'(MAX_HEIGHT);
        else
            h_eff = RW1'(h_wide);
        rx     = (radius_x_reg > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_x_reg;
        ry     = (radius_y_reg > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_y_reg;
        two_rx = {rx, 1'b0};
        two_ry = {ry, 1'b0};
        span   = two_rx + OFS_W'(1);
    end

    // handshake
    assign adv      = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && adv;
    assign in_ready = (!s1_valid_reg || adv) && !clr_busy_reg;
    assign accept   = in_valid && in_ready;
    assign pix_bit  = (pixel == PIX_FULL);

    // position of the incoming pixel and of the next one
    always_comb
    begin
        col_start  = frame_start ? '0 : col_reg;
        row_start  = frame_start ? '0 : row_reg;
        slot_start = frame_start ? '0 : slot_reg;
        col_cur    = (CW1'(col_start) >= w_eff) ? '0 : col_start;
        row_wrap   = (RW1'(row_start) >= h_eff);
        row_cur    = row_wrap ? '0 : row_start;
        slot_cur   = row_wrap ? '0 : slot_start;
        col_inc    = CW1'(col_cur) + CW1'(1);
        row_inc    = RW1'(row_cur) + RW1'(1);
        col_next   = col_inc[CW-1:0];
        row_next   = row_cur;
        slot_next  = slot_cur;
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            if (row_inc >= h_eff)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = row_inc[RW-1:0];
                slot_next = (slot_cur == SW'(ROWS - 1)) ? '0 : slot_cur + SW'(1);
            end
        end
    end

    // position registers and clear sweep control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                slot_reg <= slot_next;
            end
            if (clr_busy_reg)
            begin
                if (clr_addr_reg == CW'(MAX_WIDTH - 1))
                    clr_busy_reg <= 1'b0;
                else
                    clr_addr_reg <= clr_addr_reg + CW'(1);
            end
        end
    end

    // line store: clear sweep or write of the new bit, read of the column
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= '0;
        else if (accept)
            mem[col_cur][slot_cur] <= pix_bit;
        if (accept)
            s1_rd_reg <= mem[col_cur];
    end

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (adv)
            s1_valid_reg <= 1'b0;
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg    <= col_cur;
            s1_row_reg    <= row_cur;
            s1_slot_reg   <= slot_cur;
            s1_bit_reg    <= pix_bit;
            s1_px_nz_reg  <= (pixel != PIX_ZERO);
            s1_px2_nz_reg <= (second_pixel != PIX_ZERO);
        end
    end

    // newest column with the bit just written
    always_comb
    begin
        fresh = s1_rd_reg;
        fresh[s1_slot_reg] = s1_bit_reg;
    end

    // row offset of each slot relative to the window top
    always_comb
    begin
        logic [SW1-1:0] diff;
        for (int s = 0; s < ROWS; s++)
        begin
            diff = {1'b0, s1_slot_reg} + SW1'(ROWS) - SW1'(s);
            if (diff >= SW1'(ROWS))
                diff = diff - SW1'(ROWS);
            back_s[s] = diff[SW-1:0];
            row_ok[s] = (OFS_W'(back_s[s]) <= two_ry);
            ofs_i[s]  = two_ry - OFS_W'(back_s[s]);
        end
    end

    // element mask per tap and slot
    always_comb
    begin
        logic [OFS_W-1:0] ofs_j;
        logic             tap_ok;
        logic [BIT_W-1:0] bidx;
        for (int k = 0; k < ROWS; k++)
        begin
            tap_ok = (OFS_W'(k) <= two_rx);
            ofs_j  = two_rx - OFS_W'(k);
            for (int s = 0; s < ROWS; s++)
            begin
                bidx = BIT_W'(ofs_i[s]) * BIT_W'(span) + BIT_W'(ofs_j);
                mask_tap[k][s] = tap_ok && row_ok[s] && (bidx < BIT_W'(SE_W))
                                 && se_reg[bidx[SE_IDX_W-1:0]];
            end
        end
    end

    // chain of column cells, one place per transaction
    assign col_chain[0] = fresh;

    for (genvar g = 0; g < ROWS - 1; g++)
    begin : g_cell
        bmw_cell #(
            .ROWS (ROWS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (s1_fire),
            .col_in     (col_chain[g]),
            .mask       (mask_tap[g + 1]),
            .col_out    (col_chain[g + 1]),
            .cell_match (cell_res[g])
        );
    end

    // combine the newest column with the cell matches
    always_comb
    begin
        hit_any  = |(fresh & mask_tap[0]);
        miss_any = |(~fresh & mask_tap[0]);
        for (int k = 0; k < ROWS - 1; k++)
        begin
            hit_any  = hit_any  | cell_res[k].hit;
            miss_any = miss_any | cell_res[k].miss;
        end
    end

    // result selection
    always_comb
    begin
        morph_mode = (mode_reg == MODE_ERODE) || (mode_reg == MODE_DILATE);
        set_mode   = (mode_reg == MODE_SUBTRACT) || (mode_reg == MODE_UNION)
                     || (mode_reg == MODE_INTERSECT);
        has_result = set_mode || (morph_mode && (s1_col_reg >= CW'(two_rx))
                                  && (s1_row_reg >= RW'(two_ry)));
        unique case (mode_reg)
            MODE_ERODE:     res_bit = !miss_any;
            MODE_DILATE:    res_bit = hit_any;
            MODE_SUBTRACT:  res_bit = s1_px_nz_reg && !s1_px2_nz_reg;
            MODE_UNION:     res_bit = s1_px_nz_reg || s1_px2_nz_reg;
            MODE_INTERSECT: res_bit = s1_px_nz_reg && s1_px2_nz_reg;
            default:        res_bit = 1'b0;
        endcase
        if (morph_mode)
        begin
            res_col = POS_W'(s1_col_reg - CW'(rx));
            res_row = POS_W'(s1_row_reg - RW'(ry));
        end
        else
        begin
            res_col = POS_W'(s1_col_reg);
            res_row = POS_W'(s1_row_reg);
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s1_valid_reg && has_result;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_value_reg <= res_bit ? PIX_FULL : PIX_ZERO;
            out_col_reg   <= res_col;
            out_row_reg   <= res_row;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;

endmodule

// ===== hdl/bmw_checker.sv =====
// bmw_checker: port-level assertions for binary_morphology_window_top
// bound to the top level below; depends on bmw_pkg
module bmw_checker
    import bmw_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PIX_W-1:0] out_value
);

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("stalled result changed");

    // results are binary
    a_out_binary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_value == PIX_FULL) || (out_value == PIX_ZERO))
        else $error("result value not binary");

    // line store sweep blocks input right after reset
    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
        else $error("input taken during line store sweep");

    // a new result follows an input transaction that went through the read stage
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without input transaction");

endmodule

bind binary_morphology_window_top bmw_checker u_bmw_checker (.*);
